// File: hdl/uhb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uhb_pkg;

    // one input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_item;
        logic       carries_no_byte;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [15:0] ip_total_length;
        logic [15:0] ip_header_checksum;
        logic [15:0] udp_length;
        logic [15:0] udp_csum;
        logic        payload_too_long;
    } t_out_item;

    // payload summary handed from the accumulator to the checksum stages
    typedef struct packed {
        logic [15:0] payload_sum;
        logic [16:0] byte_count;
    } t_fin;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SRC_ADDR = 2'd0,
        CFG_DST_ADDR = 2'd1,
        CFG_SRC_PORT = 2'd2,
        CFG_DST_PORT = 2'd3
    } t_cfg_idx;

    localparam logic [16:0] MAX_PAYLOAD    = 17'd65507;
    localparam logic [16:0] COUNT_LIMIT    = 17'd131071;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
    localparam logic [15:0] IP_HDR_LEN     = 16'd20;
    localparam logic [15:0] UDP_LEN_SAT    = 16'd65515;
    localparam logic [15:0] IP_LEN_SAT     = 16'hFFFF;
    localparam logic [15:0] VER_IHL_TOS    = 16'h4500;
    localparam logic [15:0] IP_ID_WORD     = 16'haabb;
    localparam logic [15:0] FLAGS_WORD     = 16'h0000;
    localparam logic [15:0] TTL_PROTO_WORD = 16'h4011;
    localparam logic [15:0] PROTO_WORD     = 16'h0011;

    // ones' complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // fold a 20-bit raw sum down to 16 bits
    function automatic logic [15:0] oc_fold(input logic [19:0] raw);
        logic [16:0] f;
        f = {1'b0, raw[15:0]} + {13'd0, raw[19:16]};
        return f[15:0] + {15'd0, f[16]};
    endfunction

endpackage

`default_nettype wire

// File: hdl/udp_ipv4_header_builder.sv
`timescale 1ns / 1ps
`default_nettype none

// UDP/IPv4 header builder: payload bytes stream in one item per cycle while
// o_in_stall is low, and a running ones' complement sum and byte count are
// kept by a single end-around-carry add per item. The item marked final
// yields one result carrying the IPv4 total length, IPv4 header checksum, UDP
// length and UDP checksum; the summary register loads on the accepting edge,
// then the length stage register, then the checksum stage loads the output
// register and raises o_out_valid. Stall on the input side only rises while
// the output stage is held and all result stages are full. Addresses and
// ports are written through the configuration port; the user must write them
// only between payloads, as the block itself does not enforce it.
module udp_ipv4_header_builder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire uhb_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output uhb_pkg::t_out_item      o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import uhb_pkg::*;

    logic [31:0] r_src_addr;
    logic [31:0] r_dst_addr;
    logic [15:0] r_sport;
    logic [15:0] r_dst_port;

    logic        fin_valid;
    logic        fin_ready;
    t_fin        fin;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr <= '0;
            r_dst_addr <= '0;
            r_sport    <= '0;
            r_dst_port <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_ADDR: r_src_addr <= i_cfg_data;
                CFG_DST_ADDR: r_dst_addr <= i_cfg_data;
                CFG_SRC_PORT: r_sport    <= i_cfg_data[15:0];
                CFG_DST_PORT: r_dst_port <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    uhb_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_fin_valid (fin_valid),
        .i_fin_ready (fin_ready),
        .o_fin       (fin)
    );

    uhb_csum u_csum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .o_fin_ready (fin_ready),
        .i_fin       (fin),
        .i_src_addr  (r_src_addr),
        .i_dst_addr  (r_dst_addr),
        .i_sport     (r_sport),
        .i_dst_port  (r_dst_port),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // lengths stay consistent when not saturated
    a_len_relation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.payload_too_long) |->
            (o_out_item.ip_total_length == o_out_item.udp_length + IP_HDR_LEN))
        else $error("ip total length does not match udp length");

    // saturated lengths on an oversize payload
    a_len_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.payload_too_long) |->
            (o_out_item.udp_length == UDP_LEN_SAT &&
             o_out_item.ip_total_length == IP_LEN_SAT))
        else $error("oversize payload lengths not saturated");

    // a pending summary is held while the checksum stages are full
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_valid && !fin_ready) |=> (fin_valid && $stable(fin)))
        else $error("payload summary lost while stalled");

endmodule

`default_nettype wire

// File: hdl/uhb_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module uhb_accum (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire uhb_pkg::t_in_item i_in_item,
    output logic                  o_fin_valid,
    input  wire logic             i_fin_ready,
    output uhb_pkg::t_fin         o_fin
);
    import uhb_pkg::*;

    logic [15:0] r_sum;
    logic [16:0] r_count;
    logic [7:0]  r_held;
    logic        r_odd;
    logic        r_fin_vld;
    t_fin        r_fin;

    logic        ready;
    logic        accept;
    logic        has_byte;
    logic [15:0] add_word;
    logic [15:0] n_sum_word;
    logic [16:0] n_count;

    assign ready      = !r_fin_vld || i_fin_ready;
    assign o_in_stall = !ready;
    assign accept     = i_in_valid && ready;
    assign has_byte   = !i_in_item.carries_no_byte;

    // word that this item completes, the new byte padded when it opens a word, or the padded held byte on an empty item
    always_comb begin
        if (has_byte) begin
            add_word = r_odd ? {r_held, i_in_item.data_byte} : {i_in_item.data_byte, 8'h00};
        end else begin
            add_word = r_odd ? {r_held, 8'h00} : 16'h0000;
        end
        n_sum_word = oc_add(r_sum, add_word);
        n_count    = (has_byte && (r_count != COUNT_LIMIT)) ? r_count + 17'd1 : r_count;
    end

    // running sum and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_held  <= '0;
            r_odd   <= 1'b0;
        end else if (accept) begin
            if (i_in_item.final_item) begin
                r_sum   <= '0;
                r_count <= '0;
                r_held  <= '0;
                r_odd   <= 1'b0;
            end else if (has_byte) begin
                r_count <= n_count;
                if (r_odd) begin
                    r_sum  <= n_sum_word;
                    r_held <= '0;
                    r_odd  <= 1'b0;
                end else begin
                    r_held <= i_in_item.data_byte;
                    r_odd  <= 1'b1;
                end
            end
        end
    end

    // payload summary on the final item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (ready) begin
            r_fin_vld <= accept && i_in_item.final_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.final_item) begin
            r_fin.payload_sum <= n_sum_word;
            r_fin.byte_count  <= n_count;
        end
    end

    assign o_fin_valid = r_fin_vld;
    assign o_fin       = r_fin;

endmodule

`default_nettype wire

// File: hdl/uhb_csum.sv
`timescale 1ns / 1ps
`default_nettype none

module uhb_csum (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fin_valid,
    output logic                   o_fin_ready,
    input  wire uhb_pkg::t_fin     i_fin,
    input  wire logic [31:0]       i_src_addr,
    input  wire logic [31:0]       i_dst_addr,
    input  wire logic [15:0]       i_sport,
    input  wire logic [15:0]       i_dst_port,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output uhb_pkg::t_out_item     o_out_item
);
    import uhb_pkg::*;

    logic        r_b_vld;
    logic        r_b_too_long;
    logic [15:0] r_b_udp_len;
    logic [15:0] r_b_ip_len;
    logic [18:0] r_b_ip_part;
    logic [18:0] r_b_udp_part;
    logic        r_out_vld;
    t_out_item   r_out;

    logic        out_ready;
    logic        b_ready;
    logic        too_long;
    logic [15:0] udp_len;
    logic [18:0] addr_part;
    logic [19:0] ip_raw;
    logic [19:0] udp_raw;

    assign out_ready   = !r_out_vld || !i_out_stall;
    assign b_ready     = !r_b_vld || out_ready;
    assign o_fin_ready = b_ready;

    // lengths with saturation, address halves summed once for both checksums
    always_comb begin
        too_long  = i_fin.byte_count > MAX_PAYLOAD;
        udp_len   = too_long ? UDP_LEN_SAT : i_fin.byte_count[15:0] + UDP_HDR_LEN;
        addr_part = {3'd0, i_src_addr[31:16]} + {3'd0, i_src_addr[15:0]}
                  + {3'd0, i_dst_addr[31:16]} + {3'd0, i_dst_addr[15:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_ready) begin
            r_b_vld <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && i_fin_valid) begin
            r_b_too_long <= too_long;
            r_b_udp_len  <= udp_len;
            r_b_ip_len   <= too_long ? IP_LEN_SAT : udp_len + IP_HDR_LEN;
            r_b_ip_part  <= addr_part + {3'd0, VER_IHL_TOS} + {3'd0, IP_ID_WORD}
                          + {3'd0, FLAGS_WORD} + {3'd0, TTL_PROTO_WORD};
            r_b_udp_part <= addr_part + {3'd0, PROTO_WORD} + {3'd0, i_sport}
                          + {3'd0, i_dst_port} + {3'd0, i_fin.payload_sum};
        end
    end

    // add the lengths, fold and complement
    always_comb begin
        ip_raw  = {1'b0, r_b_ip_part} + {4'd0, r_b_ip_len};
        udp_raw = {1'b0, r_b_udp_part} + {3'd0, r_b_udp_len, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_b_vld) begin
            r_out.ip_total_length    <= r_b_ip_len;
            r_out.ip_header_checksum <= ~oc_fold(ip_raw);
            r_out.udp_length         <= r_b_udp_len;
            r_out.udp_csum           <= ~oc_fold(udp_raw);
            r_out.payload_too_long   <= r_b_too_long;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: verif/uhb_result_checker.sv
`timescale 1ns / 1ps

// watches both channels and the register port, predicts the header fields of
// every payload and compares them with what the block hands out
module uhb_result_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire uhb_pkg::t_in_item  i_in_item,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire uhb_pkg::t_out_item i_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output int                      o_failures,
    output int                      o_pending,
    output int                      o_checked
);

    import uhb_pkg::*;

    localparam logic [16:0] PAYLOAD_MAX_BYTES = 17'd65507;
    localparam logic [16:0] BYTE_COUNT_TOP    = 17'd131071;
    localparam logic [15:0] UDP_HEADER_BYTES  = 16'd8;
    localparam logic [15:0] IP_HEADER_BYTES   = 16'd20;
    localparam logic [15:0] UDP_LENGTH_CAP    = 16'd65515;
    localparam logic [15:0] IP_LENGTH_CAP     = 16'hFFFF;
    localparam logic [15:0] WORD_VER_TOS      = 16'h4500;
    localparam logic [15:0] WORD_IDENT        = 16'haabb;
    localparam logic [15:0] WORD_FRAGMENT     = 16'h0000;
    localparam logic [15:0] WORD_TTL_PROTO    = 16'h4011;
    localparam logic [15:0] WORD_PROTO        = 16'h0011;
    localparam int          REPORT_LIMIT      = 10;

    // register copies
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dst_port;

    // payload accumulation
    logic [15:0] word_sum;
    logic [16:0] byte_total;
    logic [7:0]  waiting_high;
    logic        half_word;

    t_out_item   expected_headers[$];
    int          fail_count = 0;
    int          checked_count = 0;

    // ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[15:0] + {15'd0, wide[16]};
    endfunction

    function automatic logic [15:0] ones_add_addr(input logic [15:0] s, input logic [31:0] addr);
        return ones_add(ones_add(s, addr[31:16]), addr[15:0]);
    endfunction

    // fold one accepted item into the payload sum, emit headers on the last one
    task automatic absorb_item(input t_in_item item);
        logic [15:0] payload_sum;
        logic [15:0] udp_len;
        logic [15:0] ip_len;
        logic [15:0] acc;
        logic        oversize;
        t_out_item   hdr;
        if (!item.carries_no_byte) begin
            if (!half_word) begin
                waiting_high = item.data_byte;
                half_word = 1'b1;
            end else begin
                word_sum = ones_add(word_sum, {waiting_high, item.data_byte});
                waiting_high = 8'd0;
                half_word = 1'b0;
            end
            if (byte_total < BYTE_COUNT_TOP)
                byte_total = byte_total + 17'd1;
        end
        if (item.final_item) begin
            payload_sum = word_sum;
            if (half_word)
                payload_sum = ones_add(payload_sum, {waiting_high, 8'd0});

            oversize = byte_total > PAYLOAD_MAX_BYTES;
            udp_len = oversize ? UDP_LENGTH_CAP : byte_total[15:0] + UDP_HEADER_BYTES;
            ip_len = oversize ? IP_LENGTH_CAP : udp_len + IP_HEADER_BYTES;

            // ipv4 header, checksum field taken as zero
            acc = ones_add(WORD_VER_TOS, ip_len);
            acc = ones_add(acc, WORD_IDENT);
            acc = ones_add(acc, WORD_FRAGMENT);
            acc = ones_add(acc, WORD_TTL_PROTO);
            acc = ones_add_addr(acc, src_addr);
            acc = ones_add_addr(acc, dst_addr);
            hdr.ip_header_checksum = ~acc;

            // pseudo-header, udp header and payload
            acc = ones_add_addr(16'd0, src_addr);
            acc = ones_add_addr(acc, dst_addr);
            acc = ones_add(acc, WORD_PROTO);
            acc = ones_add(acc, udp_len);
            acc = ones_add(acc, sport);
            acc = ones_add(acc, dst_port);
            acc = ones_add(acc, udp_len);
            acc = ones_add(acc, payload_sum);
            hdr.udp_csum = ~acc;

            hdr.ip_total_length = ip_len;
            hdr.udp_length = udp_len;
            hdr.payload_too_long = oversize;
            expected_headers.push_back(hdr);

            word_sum = 16'd0;
            byte_total = 17'd0;
            waiting_high = 8'd0;
            half_word = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    task automatic compare_result(input t_out_item got);
        t_out_item want;
        if (expected_headers.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("result with nothing expected: %h", got);
        end else begin
            want = expected_headers.pop_front();
            check_field("ip_total_length", want.ip_total_length, got.ip_total_length);
            check_field("ip_header_checksum", want.ip_header_checksum,
                        got.ip_header_checksum);
            check_field("udp_length", want.udp_length, got.udp_length);
            check_field("udp_csum", want.udp_csum, got.udp_csum);
            check_field("payload_too_long", {15'd0, want.payload_too_long},
                        {15'd0, got.payload_too_long});
            checked_count++;
        end
    endtask

    // sample every handshake at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_addr = 32'd0;
            dst_addr = 32'd0;
            sport = 16'd0;
            dst_port = 16'd0;
            word_sum = 16'd0;
            byte_total = 17'd0;
            waiting_high = 8'd0;
            half_word = 1'b0;
            expected_headers.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SRC_ADDR: src_addr = i_cfg_data;
                    CFG_DST_ADDR: dst_addr = i_cfg_data;
                    CFG_SRC_PORT: sport = i_cfg_data[15:0];
                    CFG_DST_PORT: dst_port = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                absorb_item(i_in_item);
            if (i_out_valid && !i_out_stall)
                compare_result(i_out_item);
        end
        o_pending <= expected_headers.size();
        o_failures <= fail_count;
        o_checked <= checked_count;
    end

endmodule

// File: verif/tb_udp_ipv4_header_builder.sv
`timescale 1ns / 1ps

module tb_udp_ipv4_header_builder;

    import uhb_pkg::*;

    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int PAUSE_AFTER      = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_item = '0;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_SRC_ADDR;
    logic [31:0] cfg_data = 32'd0;

    wire logic   in_stall;
    wire logic   out_valid;
    t_out_item   out_item;

    int          failures;
    int          pending;
    int          checked;

    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned noise_pct = 0;
    int          items_sent = 0;

    // 12 ns clock
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    udp_ipv4_header_builder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    uhb_result_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // offer one item, with random idle cycles ahead of it
    task automatic send_item(input logic [7:0] data, input logic last, input logic no_byte);
        t_in_item item;
        item.data_byte = data;
        item.final_item = last;
        item.carries_no_byte = no_byte;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // one payload of random bytes, with stray empty items mixed in
    task automatic send_payload(input int len, input bit close_empty);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_item(8'($urandom_range(255)), 1'b0, 1'b1);
            send_item(8'($urandom_range(255)), (i == len - 1) && !close_empty, 1'b0);
        end
        if (len == 0 || close_empty)
            send_item(8'($urandom_range(255)), 1'b1, 1'b1);
    endtask

    // mostly short payloads, a few longer ones
    function automatic int pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return 0;
        if (r < 90)
            return $urandom_range(40, 1);
        return $urandom_range(300, 41);
    endfunction

    // hold the sender until every expected result is out and the pipe is empty
    task automatic wait_for_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all four registers once the block is idle
    task automatic write_config(input logic [31:0] src, input logic [31:0] dst,
                                input logic [15:0] sport, input logic [15:0] dport);
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_index <= CFG_SRC_ADDR;
        cfg_data <= src;
        @(posedge clk);
        cfg_index <= CFG_DST_ADDR;
        cfg_data <= dst;
        @(posedge clk);
        cfg_index <= CFG_SRC_PORT;
        cfg_data <= {16'($urandom), sport};
        @(posedge clk);
        cfg_index <= CFG_DST_PORT;
        cfg_data <= {16'($urandom), dport};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_random_config();
        write_config($urandom, $urandom, 16'($urandom), 16'($urandom));
    endtask

    // random payloads under one idling pattern, with one full drain part way
    task automatic run_random_phase(input int unsigned gap, input int unsigned stall);
        int start;
        int payloads;
        send_gap_pct = gap;
        stall_pct = stall;
        noise_pct = 10;
        start = items_sent;
        payloads = 0;
        while (items_sent - start < RANDOM_PER_PHASE) begin
            send_payload(pick_length(), $urandom_range(99) < 15);
            payloads++;
            if (payloads == PAUSE_AFTER)
                wait_for_results();
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at their reset values
        send_item(8'h3c, 1'b0, 1'b0);
        send_item(8'hc3, 1'b1, 1'b0);

        // empty payload chosen so that both checksums come out as zero
        write_config(32'h0000_0000, 32'h0000_d016, 16'h0000, 16'h2fc8);
        send_item(8'ha5, 1'b1, 1'b1);

        // all registers at their top values
        write_config(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff);
        send_item(8'ha5, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        // odd length with an empty item in between
        send_item(8'h12, 1'b0, 1'b0);
        send_item(8'h77, 1'b0, 1'b1);
        send_item(8'h34, 1'b0, 1'b0);
        send_item(8'h56, 1'b1, 1'b0);
        // payloads closed by an empty final item, then one with an empty item ahead of its last byte
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h7f, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'haa, 1'b1, 1'b0);

        // random part over the idling patterns
        write_random_config();
        run_random_phase(0, 0);
        write_random_config();
        run_random_phase(48, 0);
        write_config(32'hffff_ffff, 32'h0000_0000, 16'h0000, 16'hffff);
        run_random_phase(0, 48);
        write_random_config();
        run_random_phase(26, 26);
        wait_for_results();

        $display("%0d items sent, %0d header results checked", items_sent, checked);
        $display("covered empty and odd payloads, zero checksums, idle and stall mixes");
        if (failures == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            if (pending != 0)
                $display("%0d expected results never arrived", pending);
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
